// File: rtl/core/lsc_pkg.sv
// Shared constants, codes and types of the line sensor calibration and steering block.
package lsc_pkg;

   // Field widths of the request and response beats.
   localparam int SAMPLE_W = 10;
   localparam int OP_W     = 2;
   localparam int DRIVE_W  = 8;
   localparam int ERR_W    = 8;
   localparam int LEVEL_W  = 7;
   localparam int PROD_W   = 16;

   // Number of sensor channels and which of them steer.
   localparam int CHANNELS     = 4;
   localparam int CH_CENTER_R  = 0;
   localparam int CH_CENTER_L  = 1;
   localparam int CH_OUTER_R   = 2;
   localparam int CH_OUTER_L   = 3;

   localparam int FULL_SCALE = 100;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_TRACK = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

   // Register file.
   localparam int                 CSR_ADDR_W  = 3;
   localparam int                 CSR_DATA_W  = 32;
   localparam logic               CSR_IDX_GAIN  = 1'b0;
   localparam logic               CSR_IDX_SPEED = 1'b1;
   localparam logic [DRIVE_W-1:0] GAIN_RESET  = 8'd40;
   localparam logic [DRIVE_W-1:0] SPEED_RESET = 8'd200;

   typedef struct packed {
      logic busy;
      logic zero;
   } norm_status_type;

   typedef struct packed {
      logic [DRIVE_W-1:0]       left_drive;
      logic [DRIVE_W-1:0]       right_drive;
      logic signed [ERR_W-1:0]  steer_error;
      logic [LEVEL_W-1:0]       right_level;
      logic [LEVEL_W-1:0]       left_level;
   } result_type;

endpackage

// File: rtl/core/lsc_if.sv
// Request and response channel interfaces of the line sensor block.
interface lsc_req_if;
   import lsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [SAMPLE_W-1:0] center_right_sample;
   logic [SAMPLE_W-1:0] center_left_sample;
   logic [SAMPLE_W-1:0] outer_right_sample;
   logic [SAMPLE_W-1:0] outer_left_sample;

   modport source (output valid, op, center_right_sample, center_left_sample,
                   outer_right_sample, outer_left_sample, input ready);
   modport sink   (input valid, op, center_right_sample, center_left_sample,
                   outer_right_sample, outer_left_sample, output ready);
endinterface

interface lsc_rsp_if;
   import lsc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [DRIVE_W-1:0]      left_drive;
   logic [DRIVE_W-1:0]      right_drive;
   logic signed [ERR_W-1:0] steer_error;
   logic [LEVEL_W-1:0]      right_level;
   logic [LEVEL_W-1:0]      left_level;

   modport source (output valid, left_drive, right_drive, steer_error, right_level,
                   left_level, input ready);
   modport sink   (input valid, left_drive, right_drive, steer_error, right_level,
                   left_level, output ready);
endinterface

// File: rtl/core/line_sensor_calibrate_and_steer.sv
// Top level of the line sensor calibration and proportional steering block.
//
// Requests arrive on req_bus as valid/ready beats, each with an op code and four sensor
// samples; one response beat leaves on rsp_bus for every request. Start and track ops
// load or widen the per-channel light/dark range and answer with an all-zero beat. A run
// op normalizes the two center samples to 0..100 in two lanes, each a restoring divider
// that settles one quotient bit per cycle, then forms the error, the gain product and the
// clamped left and right drives.
// One request is in work at a time. A calibration op passes through the output step into the
// response register; a run op passes through seven divider steps, the product register load
// and the output step. req_bus.ready returns in the cycle the response is offered, so a new
// request is taken only once the last one has been loaded into the response register.
// The response register holds a finished beat while the receiver stalls; the next request
// is still accepted and waits only at the output step until that beat is taken.
// The gain and base speed registers sit on the APB-style csr_ port, at byte 0 and 4, and
// should be written only while the block is idle.
// Synchronous reset clears the calibration ranges to zero, sets gain to 40 and base speed
// to 200, and empties the response register.
module line_sensor_calibrate_and_steer #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   lsc_req_if.sink                          req_bus,
   lsc_rsp_if.source                        rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import lsc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   run_ff, run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic [DRIVE_W-1:0]     gain_ff, gain_in;
   logic [DRIVE_W-1:0]     speed_ff, speed_in;

   logic                   accept;
   logic                   norm_start;
   logic                   merge_load;
   logic                   out_load;
   logic                   csr_write;
   logic                   csr_idx;

   logic [SAMPLE_BITS-1:0] samp  [CHANNELS];
   logic [SAMPLE_BITS-1:0] light [CHANNELS];
   logic [SAMPLE_BITS-1:0] dark  [CHANNELS];

   norm_status_type        right_stat, left_stat;
   logic [LEVEL_W-1:0]     right_level, left_level;
   result_type             merge_result;

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      gain_in  = gain_ff;
      speed_in = speed_ff;
      if (csr_write) begin
         if (csr_idx == CSR_IDX_GAIN) begin
            gain_in = csr_pwdata[DRIVE_W-1:0];
         end else begin
            speed_in = csr_pwdata[DRIVE_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_idx == CSR_IDX_SPEED) ? CSR_DATA_W'(speed_ff)
                                                  : CSR_DATA_W'(gain_ff);

   // Calibration lanes, one per channel.
   assign accept = req_bus.valid && req_bus.ready;

   assign samp[CH_CENTER_R] = SAMPLE_BITS'(req_bus.center_right_sample);
   assign samp[CH_CENTER_L] = SAMPLE_BITS'(req_bus.center_left_sample);
   assign samp[CH_OUTER_R]  = SAMPLE_BITS'(req_bus.outer_right_sample);
   assign samp[CH_OUTER_L]  = SAMPLE_BITS'(req_bus.outer_left_sample);

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_cal
      lsc_cal_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal (
         .clock  (clock),
         .reset  (reset),
         .update (accept),
         .op     (req_bus.op),
         .sample (samp[ch]),
         .light  (light[ch]),
         .dark   (dark[ch])
      );
   end

   // Normalization lanes for the two center channels.
   assign norm_start = accept && (req_bus.op == OP_RUN);

   lsc_norm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm_right (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sample (samp[CH_CENTER_R]),
      .light  (light[CH_CENTER_R]),
      .dark   (dark[CH_CENTER_R]),
      .status (right_stat),
      .level  (right_level)
   );

   lsc_norm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_norm_left (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sample (samp[CH_CENTER_L]),
      .light  (light[CH_CENTER_L]),
      .dark   (dark[CH_CENTER_L]),
      .status (left_stat),
      .level  (left_level)
   );

   lsc_merge u_merge (
      .clock       (clock),
      .load        (merge_load),
      .right_level (right_level),
      .left_level  (left_level),
      .gain        (gain_ff),
      .base        (speed_ff),
      .result      (merge_result)
   );

   // Sequencer.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign merge_load    = (state_ff == ST_DIV) && !right_stat.busy && !left_stat.busy;
   assign out_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               run_in   = norm_start;
               state_in = norm_start ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            if (merge_load) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: calibration and unused ops answer with all zeros.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (out_load) begin
         rsp_in       = run_ff ? merge_result : '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         speed_ff     <= SPEED_RESET;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         speed_ff     <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_drive  = rsp_ff.left_drive;
   assign rsp_bus.right_drive = rsp_ff.right_drive;
   assign rsp_bus.steer_error = rsp_ff.steer_error;
   assign rsp_bus.right_level = rsp_ff.right_level;
   assign rsp_bus.left_level  = rsp_ff.left_level;

endmodule

// File: rtl/core/lsc_cal_lane.sv
// One calibration lane: light maximum and dark minimum of a single sensor channel.
module lsc_cal_lane #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  logic [lsc_pkg::OP_W-1:0] op,
   input  logic [SAMPLE_BITS-1:0]   sample,
   output logic [SAMPLE_BITS-1:0]   light,
   output logic [SAMPLE_BITS-1:0]   dark
);
   import lsc_pkg::*;

   logic [SAMPLE_BITS-1:0] light_ff, light_in;
   logic [SAMPLE_BITS-1:0] dark_ff, dark_in;

   always_comb begin
      light_in = light_ff;
      dark_in  = dark_ff;
      if (update) begin
         case (op)
            OP_START: begin
               light_in = sample;
               dark_in  = sample;
            end
            OP_TRACK: begin
               // The range only widens, and one side moves per beat.
               if (sample > light_ff) begin
                  light_in = sample;
               end else if (sample < dark_ff) begin
                  dark_in = sample;
               end
            end
            default: begin
               light_in = light_ff;
               dark_in  = dark_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff <= '0;
         dark_ff  <= '0;
      end else begin
         light_ff <= light_in;
         dark_ff  <= dark_in;
      end
   end

   assign light = light_ff;
   assign dark  = dark_ff;

endmodule

// File: rtl/core/lsc_norm_lane.sv
// One normalization lane: (sample-dark)*100/(light-dark) by restoring division, a bit a cycle.
module lsc_norm_lane #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [SAMPLE_BITS-1:0]       sample,
   input  logic [SAMPLE_BITS-1:0]       light,
   input  logic [SAMPLE_BITS-1:0]       dark,
   output lsc_pkg::norm_status_type     status,
   output logic [lsc_pkg::LEVEL_W-1:0]  level
);
   import lsc_pkg::*;

   localparam int REM_W = SAMPLE_BITS + LEVEL_W;
   localparam int DIV_W = SAMPLE_BITS + LEVEL_W - 1;
   localparam int CNT_W = $clog2(LEVEL_W);

   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       div_ff, div_in;
   logic [LEVEL_W-1:0]     quo_ff, quo_in;
   logic                   zero_ff, zero_in;
   logic                   sat_ff, sat_in;

   logic [SAMPLE_BITS-1:0] span;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   fits;

   assign span = light - dark;
   assign diff = sample - dark;
   assign fits = rem_ff >= REM_W'(div_ff);

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      zero_in  = zero_ff;
      sat_in   = sat_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(LEVEL_W - 1);
         // An empty span or a sample at or below dark reads as zero.
         zero_in  = (light <= dark) || (sample <= dark);
         sat_in   = sample >= light;
         rem_in   = REM_W'(diff) * REM_W'(FULL_SCALE);
         div_in   = DIV_W'(span) << (LEVEL_W - 1);
         quo_in   = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - REM_W'(div_ff);
         end
         quo_in = {quo_ff[LEVEL_W-2:0], fits};
         div_in = div_ff >> 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
   end

   assign status.busy = busy_ff;
   assign status.zero = zero_ff;

   always_comb begin
      if (zero_ff) begin
         level = '0;
      end else if (sat_ff) begin
         level = LEVEL_W'(FULL_SCALE);
      end else begin
         level = quo_ff;
      end
   end

endmodule

// File: rtl/core/lsc_merge.sv
// Merge stage: error of the two center lanes, gain product, and clamped drive levels.
module lsc_merge (
   input  logic                         clock,
   input  logic                         load,
   input  logic [lsc_pkg::LEVEL_W-1:0]  right_level,
   input  logic [lsc_pkg::LEVEL_W-1:0]  left_level,
   input  logic [lsc_pkg::DRIVE_W-1:0]  gain,
   input  logic [lsc_pkg::DRIVE_W-1:0]  base,
   output lsc_pkg::result_type          result
);
   import lsc_pkg::*;

   localparam int SUM_W = PROD_W + 2;

   logic signed [ERR_W-1:0]     err;
   logic signed [PROD_W:0]      prod_full;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ERR_W-1:0]     err_ff;
   logic [LEVEL_W-1:0]          right_ff;
   logic [LEVEL_W-1:0]          left_ff;
   logic signed [SUM_W-1:0]     base_ext;
   logic signed [SUM_W-1:0]     prod_ext;
   logic signed [SUM_W-1:0]     left_sum;
   logic signed [SUM_W-1:0]     right_sum;

   assign err       = $signed(ERR_W'(right_level)) - $signed(ERR_W'(left_level));
   assign prod_full = $signed({1'b0, gain}) * err;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= prod_full[PROD_W-1:0];
         err_ff   <= err;
         right_ff <= right_level;
         left_ff  <= left_level;
      end
   end

   assign base_ext  = $signed(SUM_W'(base));
   assign prod_ext  = $signed({{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
   assign left_sum  = base_ext + prod_ext;
   assign right_sum = base_ext - prod_ext;

   function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] v);
      logic [DRIVE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SUM_W'({DRIVE_W{1'b1}}))) begin
         r = '1;
      end else begin
         r = v[DRIVE_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      result.left_drive  = clamp_drive(left_sum);
      result.right_drive = clamp_drive(right_sum);
      result.steer_error = err_ff;
      result.right_level = right_ff;
      result.left_level  = left_ff;
   end

endmodule

// File: rtl/core/lsc_checker.sv
// Port-level checker for the line sensor block, bound to the top level.
module lsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lsc_pkg::ERR_W-1:0]       rsp_steer_error,
   input logic [lsc_pkg::LEVEL_W-1:0]     rsp_right_level,
   input logic [lsc_pkg::LEVEL_W-1:0]     rsp_left_level
);
   import lsc_pkg::*;

   // A response beat that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // The error field is always the difference of the two levels.
   a_err_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_steer_error ==
         ERR_W'({1'b0, rsp_right_level} - {1'b0, rsp_left_level}))
      else $error("steer error does not match the levels");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_level <= LEVEL_W'(FULL_SCALE)) &&
                    (rsp_left_level <= LEVEL_W'(FULL_SCALE)))
      else $error("level beyond full scale");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind line_sensor_calibrate_and_steer lsc_checker u_lsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_steer_error (rsp_bus.steer_error),
   .rsp_right_level (rsp_bus.right_level),
   .rsp_left_level  (rsp_bus.left_level)
);

// File: dv/tb_line_sensor_calibrate_and_steer.sv
// Self-checking testbench of the line sensor calibration and steering block.
module tb_line_sensor_calibrate_and_steer;
   timeunit 1ns;
   timeprecision 1ps;

   import lsc_pkg::*;

   localparam logic [OP_W-1:0]       OP_UNUSED       = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] SPEED_ADDR      = 3'd4;
   localparam int                    DIR_ROWS        = 20;
   localparam int                    PHASES          = 7;
   localparam int                    STEADY_PHASE    = 3;
   localparam int                    ITEMS_PER_PHASE = 235;
   localparam int                    TAIL_CYCLES     = 30;
   localparam logic [SAMPLE_W-1:0]   S_MAX           = 10'd1023;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SAMPLE_W-1:0] center_right;
      logic [SAMPLE_W-1:0] center_left;
      logic [SAMPLE_W-1:0] outer_right;
      logic [SAMPLE_W-1:0] outer_left;
   } sensor_beat_type;

   typedef struct packed {
      sensor_beat_type beat;
      logic            typed;
      result_type      want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lsc_req_if req_bus ();
   lsc_rsp_if rsp_bus ();

   line_sensor_calibrate_and_steer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Calibration ranges and register values as the block should hold them.
   logic [SAMPLE_W-1:0] light_hi [CHANNELS];
   logic [SAMPLE_W-1:0] dark_lo  [CHANNELS];
   logic [DRIVE_W-1:0]  gain_q;
   logic [DRIVE_W-1:0]  speed_q;

   result_type  pending_results [$];
   int unsigned mismatches;
   logic        steady;

   logic [DRIVE_W-1:0] phase_gain  [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd40, 8'd255, 8'd2, 8'd0};
   logic [DRIVE_W-1:0] phase_speed [PHASES] = '{8'd0, 8'd255, 8'd128, 8'd200, 8'd0, 8'd100,
                                                8'd255};

   dir_row_type dir_rows [DIR_ROWS] = '{
      // Ranges are all zero after reset, so both levels are zero.
      '{'{OP_RUN,    S_MAX,  10'd0,   10'd0,   10'd0},   1'b1,
        '{8'd200, 8'd200, 8'sd0, 7'd0, 7'd0}},
      '{'{OP_UNUSED, S_MAX,  S_MAX,   S_MAX,   S_MAX},   1'b1, '0},
      '{'{OP_START,  S_MAX,  S_MAX,   S_MAX,   S_MAX},   1'b1, '0},
      '{'{OP_TRACK,  10'd0,  10'd0,   10'd0,   10'd0},   1'b1, '0},
      '{'{OP_RUN,    S_MAX,  10'd0,   10'd512, 10'd512}, 1'b1,
        '{8'd255, 8'd0, 8'sd100, 7'd100, 7'd0}},
      '{'{OP_RUN,    10'd0,  S_MAX,   10'd0,   S_MAX},   1'b1,
        '{8'd0, 8'd255, -8'sd100, 7'd0, 7'd100}},
      '{'{OP_RUN,    10'd512, 10'd512, 10'd0,  10'd0},   1'b0, '0},
      '{'{OP_RUN,    S_MAX,  S_MAX,   S_MAX,   S_MAX},   1'b1,
        '{8'd200, 8'd200, 8'sd0, 7'd100, 7'd100}},
      '{'{OP_START,  10'd300, 10'd300, 10'd300, 10'd300}, 1'b1, '0},
      // Start leaves no span, so even a sample above light reads zero.
      '{'{OP_RUN,    S_MAX,  10'd0,   10'd0,   10'd0},   1'b1,
        '{8'd200, 8'd200, 8'sd0, 7'd0, 7'd0}},
      '{'{OP_TRACK,  10'd700, 10'd100, 10'd700, 10'd100}, 1'b1, '0},
      '{'{OP_TRACK,  10'd100, 10'd700, 10'd100, 10'd700}, 1'b1, '0},
      '{'{OP_TRACK,  10'd500, 10'd500, 10'd500, 10'd500}, 1'b1, '0},
      '{'{OP_RUN,    10'd50,  10'd900, 10'd0,   10'd0},   1'b1,
        '{8'd0, 8'd255, -8'sd100, 7'd0, 7'd100}},
      '{'{OP_RUN,    10'd400, 10'd400, 10'd0,   10'd0},   1'b0, '0},
      '{'{OP_RUN,    10'd100, 10'd700, S_MAX,   S_MAX},   1'b1,
        '{8'd0, 8'd255, -8'sd100, 7'd0, 7'd100}},
      '{'{OP_RUN,    10'd700, 10'd100, 10'd0,   10'd0},   1'b1,
        '{8'd255, 8'd0, 8'sd100, 7'd100, 7'd0}},
      '{'{OP_UNUSED, 10'd0,  10'd0,   10'd0,   10'd0},   1'b1, '0},
      '{'{OP_RUN,    10'd123, 10'd456, 10'd0,   10'd0},   1'b0, '0},
      '{'{OP_RUN,    10'd701, 10'd99,  10'd0,   10'd0},   1'b1,
        '{8'd255, 8'd0, 8'sd100, 7'd100, 7'd0}}
   };

   function automatic int level_of(input int s, input int dark, input int light);
      int span;
      int diff;
      span = light - dark;
      diff = s - dark;
      if (span <= 0 || diff <= 0) return 0;
      if (diff >= span) return FULL_SCALE;
      return diff * FULL_SCALE / span;
   endfunction

   function automatic logic [DRIVE_W-1:0] clamp_drive(input int v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[DRIVE_W-1:0];
   endfunction

   // Applies one beat to the calibration ranges and returns the result it should produce.
   function automatic result_type steer_step(input sensor_beat_type b);
      result_type          res;
      logic [SAMPLE_W-1:0] s [CHANNELS];
      int                  right;
      int                  left;
      int                  err;
      int                  corr;
      res = '0;
      s[CH_CENTER_R] = b.center_right;
      s[CH_CENTER_L] = b.center_left;
      s[CH_OUTER_R]  = b.outer_right;
      s[CH_OUTER_L]  = b.outer_left;
      case (b.op)
         OP_START: begin
            for (int i = 0; i < CHANNELS; i++) begin
               light_hi[i] = s[i];
               dark_lo[i]  = s[i];
            end
         end
         OP_TRACK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (s[i] > light_hi[i]) light_hi[i] = s[i];
               else if (s[i] < dark_lo[i]) dark_lo[i] = s[i];
            end
         end
         OP_RUN: begin
            right = level_of(int'(s[CH_CENTER_R]), int'(dark_lo[CH_CENTER_R]),
                             int'(light_hi[CH_CENTER_R]));
            left  = level_of(int'(s[CH_CENTER_L]), int'(dark_lo[CH_CENTER_L]),
                             int'(light_hi[CH_CENTER_L]));
            err   = right - left;
            corr  = int'(gain_q) * err;
            res.left_drive  = clamp_drive(int'(speed_q) + corr);
            res.right_drive = clamp_drive(int'(speed_q) - corr);
            res.steer_error = err[ERR_W-1:0];
            res.right_level = right[LEVEL_W-1:0];
            res.left_level  = left[LEVEL_W-1:0];
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return S_MAX;
      return SAMPLE_W'($urandom_range(1023));
   endfunction

   function automatic sensor_beat_type rand_beat(input logic [OP_W-1:0] op);
      sensor_beat_type b;
      b.op           = op;
      b.center_right = rand_sample();
      b.center_left  = rand_sample();
      b.outer_right  = rand_sample();
      b.outer_left   = rand_sample();
      return b;
   endfunction

   // Drives one request beat, waits for it to be taken and records its expected result.
   task automatic send_beat(input sensor_beat_type b, input logic typed,
                            input result_type want);
      result_type predicted;
      if (!steady && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_bus.valid               <= 1'b1;
      req_bus.op                  <= b.op;
      req_bus.center_right_sample <= b.center_right;
      req_bus.center_left_sample  <= b.center_left;
      req_bus.outer_right_sample  <= b.outer_right;
      req_bus.outer_left_sample   <= b.outer_left;
      do @(posedge clock); while (!req_bus.ready);
      predicted = steer_step(b);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [DRIVE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == GAIN_ADDR) gain_q = value;
      else speed_q = value;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Result side: random back-pressure and comparison against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, actual %h", $time,
                        {rsp_bus.left_drive, rsp_bus.right_drive, rsp_bus.steer_error,
                         rsp_bus.right_level, rsp_bus.left_level});
            end else begin
               want = pending_results.pop_front();
               check_field("left_drive", {8'd0, want.left_drive}, {8'd0, rsp_bus.left_drive});
               check_field("right_drive", {8'd0, want.right_drive},
                           {8'd0, rsp_bus.right_drive});
               check_field("steer_error", want.steer_error, rsp_bus.steer_error);
               check_field("right_level", {9'd0, want.right_level},
                           {9'd0, rsp_bus.right_level});
               check_field("left_level", {9'd0, want.left_level}, {9'd0, rsp_bus.left_level});
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 23);
      end
   end

   initial begin
      int sent;
      int pick;
      int n_track;
      int n_run;
      logic [DRIVE_W-1:0] g;
      logic [DRIVE_W-1:0] sp;

      mismatches = 0;
      steady     = 1'b0;
      gain_q     = GAIN_RESET;
      speed_q    = SPEED_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         light_hi[i] = '0;
         dark_lo[i]  = '0;
      end
      reset                       <= 1'b1;
      req_bus.valid               <= 1'b0;
      req_bus.op                  <= OP_START;
      req_bus.center_right_sample <= '0;
      req_bus.center_left_sample  <= '0;
      req_bus.outer_right_sample  <= '0;
      req_bus.outer_left_sample   <= '0;
      csr_psel                    <= 1'b0;
      csr_penable                 <= 1'b0;
      csr_pwrite                  <= 1'b0;
      csr_paddr                   <= GAIN_ADDR;
      csr_pwdata                  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drain();
         g  = phase_gain[ph];
         sp = phase_speed[ph];
         if (ph == PHASES - 2) begin
            g  = DRIVE_W'($urandom_range(15));
            sp = DRIVE_W'($urandom_range(255));
         end
         csr_write(GAIN_ADDR, g);
         csr_write(SPEED_ADDR, sp);
         steady = (ph == STEADY_PHASE);
         sent   = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               send_beat(rand_beat(OP_UNUSED), 1'b0, '0);
               sent += 1;
            end else if (pick < 18) begin
               // Run and track beats on top of whatever range is left over.
               n_run = $urandom_range(1, 6);
               for (int k = 0; k < n_run; k++) begin
                  send_beat(rand_beat($urandom_range(3) == 0 ? OP_TRACK : OP_RUN), 1'b0, '0);
               end
               sent += n_run;
            end else begin
               n_track = $urandom_range(0, 8);
               n_run   = $urandom_range(1, 12);
               send_beat(rand_beat(OP_START), 1'b0, '0);
               for (int k = 0; k < n_track; k++) send_beat(rand_beat(OP_TRACK), 1'b0, '0);
               for (int k = 0; k < n_run; k++) send_beat(rand_beat(OP_RUN), 1'b0, '0);
               sent += 1 + n_track + n_run;
            end
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS line_sensor_calibrate_and_steer");
      end else begin
         $display("FAIL line_sensor_calibrate_and_steer");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL line_sensor_calibrate_and_steer");
      $finish;
   end

endmodule
